[design/shtl_pkg.sv]
// ----------------------------------------------------------------------------
// shtl_pkg
// Shared constants, types and state codes for the symbol hash table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package shtl_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int NAME_CHARS  = 8;
  localparam int MISS_LIMIT  = 200;

  localparam int CHAR_W   = 8;
  localparam int NAME_W   = NAME_CHARS * CHAR_W;
  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int PROBE_W  = $clog2(TABLE_SLOTS + 1);
  localparam int CNT_W    = $clog2(NAME_CHARS + 1);
  localparam int HASH_W   = 16;
  localparam int HBIT_W   = $clog2(HASH_W);
  localparam int MISS_W   = 9;
  localparam int ENTRY_W  = NAME_W + 1;
  localparam int IDX_OUT_W = 8;
  localparam int MUL_SHIFT = 2;
  localparam int END_SHIFT = 5;
  localparam bit SLOTS_POW2 = (TABLE_SLOTS == (1 << SLOT_W));

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_ADDR,
    S_CMP,
    S_FINISH
  } state_t;

  typedef logic [NAME_CHARS-1:0][CHAR_W-1:0] name_t;

endpackage

`default_nettype wire

[design/shtl_in_if.sv]
// ----------------------------------------------------------------------------
// shtl_in_if
// Character request channel: one name character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface shtl_in_if import shtl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] name_char;
  logic              last_char;
  logic              install;

  modport source (output valid, name_char, last_char, install, input ready);
  modport sink   (input valid, name_char, last_char, install, output ready);
endinterface

`default_nettype wire

[design/shtl_out_if.sv]
// ----------------------------------------------------------------------------
// shtl_out_if
// Lookup result channel: status and slot index per name.
// ----------------------------------------------------------------------------
`default_nettype none

interface shtl_out_if import shtl_pkg::*;;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [IDX_OUT_W-1:0] slot_index;

  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

`default_nettype wire

[design/shtl_ram.sv]
// ----------------------------------------------------------------------------
// shtl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/symbol_hash_table_lookup.sv]
// ----------------------------------------------------------------------------
// symbol_hash_table_lookup
// Open-addressing symbol table with odd-stride probing.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one name character per request; last_char marks the end
//   of the name and install is sampled with it. out_res returns one result
//   per name: status (found, inserted, absent, overflow) and slot index.
//   Characters that are not last are taken while the block is idle. The final
//   character starts a lookup: S_ADDR issues the home-slot read, S_CMP
//   checks one probed slot per visit (a single table RAM read port with
//   registered read data), and S_FINISH posts the result. With a table size
//   that is not a power of two, the home-slot reduction first runs in S_MOD,
//   one hash bit per cycle.
//   After reset the table RAM is cleared one slot per cycle, every slot in
//   turn, with in_req.ready low. The result sits in an output register;
//   while it is stalled, characters of the next name are still taken, and
//   a finished lookup waits until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_hash_table_lookup import shtl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  shtl_in_if.sink   in_req,
  shtl_out_if.source out_res
);

  state_t               state_r, state_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [HASH_W-1:0]    sum_r, sum_nxt;
  logic [HBIT_W-1:0]    bit_r, bit_nxt;
  logic [SLOT_W:0]      rem_r, rem_nxt;
  name_t                name_r, name_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 inst_r, inst_nxt;
  logic [MISS_W-1:0]    miss_r, miss_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SLOT_W-1:0]    stride_r, stride_nxt;
  logic [PROBE_W-1:0]   probe_r, probe_nxt;
  logic [SLOT_W-1:0]    clr_r, clr_nxt;
  status_t              res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;

  logic                 accept;
  logic [CHAR_W-1:0]    c;
  logic [HASH_W-1:0]    hash_upd;
  logic [HASH_W-1:0]    hash_fin;
  logic [SLOT_W:0]      rem_sh;
  logic [SLOT_W:0]      idx_sum;
  logic [SLOT_W:0]      stride_sum;
  logic [SLOT_W-1:0]    idx_step;
  logic [SLOT_W-1:0]    stride_step;
  logic [PROBE_W-1:0]   probe_inc;
  logic [MISS_W-1:0]    miss_inc;
  logic                 ent_valid;
  logic                 ent_match;
  logic                 tbl_full;
  logic                 out_free;

  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;

  shtl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_tbl (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_nxt),
    .rdata (rdata)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign c        = in_req.name_char;
  assign hash_upd = HASH_W'({hash_r, MUL_SHIFT'(0)}) + HASH_W'(c);
  assign hash_fin = hash_upd + HASH_W'({c, END_SHIFT'(0)});
  assign rem_sh   = {rem_r[SLOT_W-1:0], sum_r[HASH_W-1]};

  assign idx_sum     = {1'b0, idx_r} + {1'b0, stride_r};
  assign stride_sum  = {1'b0, stride_r} + (SLOT_W+1)'(2);
  assign idx_step    = (idx_sum >= (SLOT_W+1)'(TABLE_SLOTS))
                       ? SLOT_W'(idx_sum - (SLOT_W+1)'(TABLE_SLOTS)) : idx_sum[SLOT_W-1:0];
  assign stride_step = (stride_sum >= (SLOT_W+1)'(TABLE_SLOTS))
                       ? SLOT_W'(stride_sum - (SLOT_W+1)'(TABLE_SLOTS))
                       : stride_sum[SLOT_W-1:0];
  assign probe_inc   = probe_r + PROBE_W'(1);
  assign miss_inc    = (miss_r == '1) ? miss_r : miss_r + MISS_W'(1);

  assign ent_valid = rdata[NAME_W];
  assign ent_match = (rdata[NAME_W-1:0] == name_r);
  assign tbl_full  = ent_valid && !ent_match && (32'(probe_inc) >= TABLE_SLOTS);
  assign out_free  = !out_valid_r || out_res.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && in_req.last_char) begin
          state_nxt = SLOTS_POW2 ? S_ADDR : S_MOD;
        end
      end
      S_MOD: begin
        if (bit_r == HBIT_W'(HASH_W - 1)) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: state_nxt = S_CMP;
      S_CMP: begin
        if (!ent_valid || ent_match || tbl_full) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    hash_nxt       = hash_r;
    sum_nxt        = sum_r;
    bit_nxt        = bit_r;
    rem_nxt        = rem_r;
    name_nxt       = name_r;
    cnt_nxt        = cnt_r;
    inst_nxt       = inst_r;
    miss_nxt       = miss_r;
    idx_nxt        = idx_r;
    stride_nxt     = stride_r;
    probe_nxt      = probe_r;
    clr_nxt        = clr_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = {1'b1, name_r};
    in_req.ready   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + SLOT_W'(1);
      end
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (accept) begin
          hash_nxt = hash_upd;
          for (int i = 0; i < NAME_CHARS; i++) begin
            if (cnt_r == CNT_W'(i)) begin
              name_nxt[i] = c;
            end
          end
          if (32'(cnt_r) < NAME_CHARS) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_req.last_char) begin
            hash_nxt   = '0;
            inst_nxt   = in_req.install;
            sum_nxt    = hash_fin;
            bit_nxt    = '0;
            rem_nxt    = '0;
            idx_nxt    = hash_fin[SLOT_W-1:0];
            stride_nxt = SLOT_W'(1);
            probe_nxt  = '0;
          end
        end
      end
      S_MOD: begin
        rem_nxt = (rem_sh >= (SLOT_W+1)'(TABLE_SLOTS))
                  ? rem_sh - (SLOT_W+1)'(TABLE_SLOTS) : rem_sh;
        sum_nxt = {sum_r[HASH_W-2:0], 1'b0};
        bit_nxt = bit_r + HBIT_W'(1);
        idx_nxt = rem_nxt[SLOT_W-1:0];
      end
      S_ADDR: begin
        idx_nxt = idx_r;
      end
      S_CMP: begin
        if (!ent_valid || !ent_match) begin
          if (ent_valid && !tbl_full) begin
            probe_nxt  = probe_inc;
            idx_nxt    = idx_step;
            stride_nxt = stride_step;
          end else begin
            miss_nxt = miss_inc;
            if (32'(miss_inc) >= MISS_LIMIT || ent_valid) begin
              res_nxt = ST_OVERFLOW;
            end else if (inst_r) begin
              res_nxt = ST_INSERTED;
              we      = 1'b1;
            end else begin
              res_nxt = ST_ABSENT;
            end
          end
        end else begin
          res_nxt = ST_FOUND;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_idx_nxt    = IDX_OUT_W'(idx_r);
          name_nxt       = '0;
          cnt_nxt        = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hash_r      <= '0;
      name_r      <= '0;
      cnt_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hash_r      <= hash_nxt;
      name_r      <= name_nxt;
      cnt_r       <= cnt_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r        <= sum_nxt;
    bit_r        <= bit_nxt;
    rem_r        <= rem_nxt;
    inst_r       <= inst_nxt;
    idx_r        <= idx_nxt;
    stride_r     <= stride_nxt;
    probe_r      <= probe_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.status     = out_status_r;
  assign out_res.slot_index = out_idx_r;

endmodule

`default_nettype wire

[design/shtl_chk.sv]
// ----------------------------------------------------------------------------
// shtl_chk
// Port-level checks for the symbol hash table lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_chk import shtl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_last,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           out_status,
  input wire logic [IDX_OUT_W-1:0] out_slot_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_slot_index))
    else $error("result changed while stalled");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request taken during lookup");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels active right after reset");

endmodule

bind symbol_hash_table_lookup shtl_chk u_shtl_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .in_last        (in_req.last_char),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_status     (out_res.status),
  .out_slot_index (out_res.slot_index)
);

`default_nettype wire

[verif/symbol_hash_table_lookup_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_hash_table_lookup_tb
// Streams symbol names one character per request into the lookup block and
// checks every status and slot index against a cycle-free table model kept
// in the bench. Directed names hit insert, absent, probe collisions, zero and
// maximum characters and names longer than the compared width; random names
// mix a reused pool with fresh names until ITEM_TARGET characters are queued.
// ----------------------------------------------------------------------------
module symbol_hash_table_lookup_tb;
  import shtl_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_TARGET  = 1200;
  localparam int POOL_MAX     = 48;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              inst;
    logic              barrier;
  } char_req_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] slot;
  } lookup_res_t;

  typedef struct packed {
    logic [15:0][CHAR_W-1:0] ch;
    logic [4:0]              len;
  } sym_name_t;

  logic clk;
  logic rst_n;

  shtl_in_if  in_req ();
  shtl_out_if out_res ();

  symbol_hash_table_lookup i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  always #1 clk = ~clk;

  // table model
  logic [NAME_W-1:0] tbl_name [TABLE_SLOTS];
  bit                tbl_used [TABLE_SLOTS];
  int unsigned       miss_total;
  logic [HASH_W-1:0] hash_acc;
  logic [NAME_W-1:0] name_acc;
  int unsigned       name_len;

  char_req_t   char_queue [$];
  lookup_res_t pending_results [$];
  sym_name_t   name_pool [$];

  char_req_t   offered;
  int          burst_left;
  int          gap_left;
  int          stall_left;
  int          stall_mode;
  int          hold_left;
  int          results_seen;
  int          idle_cycles;
  int          mismatch_count;
  int          error_count;
  int          item_total;

  function automatic void track_char(input char_req_t r);
    logic [HASH_W-1:0] h;
    int unsigned       slot;
    int unsigned       stride;
    int unsigned       probes;
    bit                hit;
    lookup_res_t       res;
    hash_acc = (hash_acc << MUL_SHIFT) + HASH_W'(r.ch);
    if (name_len < NAME_CHARS) begin
      name_acc = name_acc | (NAME_W'(r.ch) << (CHAR_W * name_len));
      name_len++;
    end
    if (r.last) begin
      h      = hash_acc + (HASH_W'(r.ch) << END_SHIFT);
      slot   = int'(h) % TABLE_SLOTS;
      stride = 1;
      probes = 0;
      hit    = 1'b0;
      while (tbl_used[slot]) begin
        if (tbl_name[slot] == name_acc) begin
          hit = 1'b1;
          break;
        end
        probes++;
        if (probes >= TABLE_SLOTS) break;
        slot   = (slot + stride) % TABLE_SLOTS;
        stride = stride + 2;
      end
      if (hit) begin
        res.status = ST_FOUND;
      end else begin
        if (miss_total < 511) miss_total++;
        if (miss_total >= MISS_LIMIT || tbl_used[slot]) begin
          res.status = ST_OVERFLOW;
        end else if (r.inst) begin
          tbl_name[slot] = name_acc;
          tbl_used[slot] = 1'b1;
          res.status     = ST_INSERTED;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      res.slot = IDX_OUT_W'(slot);
      pending_results.push_back(res);
      hash_acc = '0;
      name_acc = '0;
      name_len = 0;
    end
  endfunction

  function automatic sym_name_t random_name();
    sym_name_t n;
    int        pick;
    n    = '0;
    pick = $urandom_range(0, 9);
    if (pick < 7) n.len = 5'($urandom_range(1, 4));
    else if (pick < 9) n.len = 5'($urandom_range(5, 8));
    else n.len = 5'($urandom_range(9, 12));
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 15) == 0) n.ch[i] = '0;
      else n.ch[i] = CHAR_W'($urandom_range(1, 255));
    end
    return n;
  endfunction

  task automatic push_name(input sym_name_t n, input bit inst);
    char_req_t r;
    for (int i = 0; i < int'(n.len); i++) begin
      r.ch      = n.ch[i];
      r.last    = (i == int'(n.len) - 1);
      r.inst    = r.last ? inst : 1'($urandom_range(0, 1));
      r.barrier = 1'b0;
      char_queue.push_back(r);
    end
    item_total += int'(n.len);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid     <= 1'b0;
      in_req.name_char <= '0;
      in_req.last_char <= 1'b0;
      in_req.install   <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) track_char(offered);
      if (!in_req.valid || in_req.ready) begin
        if (char_queue.size() != 0 && char_queue[0].barrier && pending_results.size() == 0)
          void'(char_queue.pop_front());
        if (gap_left != 0) begin
          gap_left--;
          in_req.valid <= 1'b0;
        end else if (char_queue.size() != 0 && !char_queue[0].barrier) begin
          offered          = char_queue.pop_front();
          in_req.valid     <= 1'b1;
          in_req.name_char <= offered.ch;
          in_req.last_char <= offered.last;
          in_req.install   <= offered.inst;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 12);
              default: gap_left = $urandom_range(13, 40);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        results_seen++;
        if (results_seen == 40) hold_left = HOLD_CYCLES;
        if (pending_results.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d slot %0d",
                     out_res.status, out_res.slot_index);
        end else if (out_res.status !== pending_results[0].status ||
                     out_res.slot_index !== pending_results[0].slot) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     pending_results[0].status, pending_results[0].slot,
                     out_res.status, out_res.slot_index);
          void'(pending_results.pop_front());
        end else begin
          void'(pending_results.pop_front());
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
          0, 1: out_res.ready <= 1'b1;
          2: out_res.ready <= 1'($urandom_range(0, 1));
          default: out_res.ready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sym_name_t n;
    int        reuse_pct;
    int        idx;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_req.valid     = 1'b0;
    in_req.name_char = '0;
    in_req.last_char = 1'b0;
    in_req.install   = 1'b0;
    out_res.ready    = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_name[i] = '0;
      tbl_used[i] = 1'b0;
    end
    miss_total     = 0;
    hash_acc       = '0;
    name_acc       = '0;
    name_len       = 0;
    offered        = '0;
    burst_left     = 0;
    gap_left       = 0;
    stall_left     = 0;
    stall_mode     = 0;
    hold_left      = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    mismatch_count = 0;
    error_count    = 0;
    item_total     = 0;

    // absent, then inserted
    n = '0; n.len = 5'd1; n.ch[0] = 8'h41;
    push_name(n, 1'b0);
    push_name(n, 1'b1);
    // two names sharing a home slot, then a found one further down the chain
    n = '0; n.len = 5'd2; n.ch[0] = 8'h10; n.ch[1] = 8'h20;
    push_name(n, 1'b1);
    n.ch[0] = 8'h50;
    push_name(n, 1'b1);
    push_name(n, 1'b0);
    // maximum and zero characters
    n = '0; n.len = 5'd2; n.ch[0] = 8'hFF; n.ch[1] = 8'h00;
    push_name(n, 1'b1);
    // long name, then one differing only past the compared width
    n = random_name(); n.len = 5'd9;
    for (int i = 0; i < 9; i++) if (n.ch[i] == '0) n.ch[i] = 8'h5A;
    push_name(n, 1'b1);
    n.ch[8] = ~n.ch[8];
    push_name(n, 1'b0);
    char_queue.push_back('{ch: '0, last: 1'b0, inst: 1'b0, barrier: 1'b1});

    reuse_pct = 55;
    while (item_total < ITEM_TARGET) begin
      if (item_total >= ITEM_TARGET / 2 && reuse_pct == 55) begin
        char_queue.push_back('{ch: '0, last: 1'b0, inst: 1'b0, barrier: 1'b1});
        reuse_pct = 30;
      end
      if (name_pool.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
        idx = $urandom_range(0, name_pool.size() - 1);
        n   = name_pool[idx];
        if (n.len > NAME_CHARS && $urandom_range(0, 1) == 1)
          for (int i = NAME_CHARS; i < 16; i++) n.ch[i] = CHAR_W'($urandom_range(0, 255));
      end else begin
        n = random_name();
        if (name_pool.size() < POOL_MAX) name_pool.push_back(n);
        else name_pool[$urandom_range(0, POOL_MAX - 1)] = n;
      end
      push_name(n, $urandom_range(0, 4) != 0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (char_queue.size() != 0 || in_req.valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/shtl_pkg.sv
design/shtl_in_if.sv
design/shtl_out_if.sv
design/shtl_ram.sv
design/symbol_hash_table_lookup.sv
design/shtl_chk.sv
verif/symbol_hash_table_lookup_tb.sv
